@@ rtl/core/fourfsk_rrc_interpolating_modulator_assert.svh @@
// Assertion macros used by the checker of the 4FSK modulator.
`ifndef FOURFSK_RRC_INTERPOLATING_MODULATOR_ASSERT_SVH
`define FOURFSK_RRC_INTERPOLATING_MODULATOR_ASSERT_SVH

// Consequent checked in the cycle after the antecedent, off while in reset.
`define FSKRRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the same cycle as the antecedent, off while in reset.
`define FSKRRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Same-cycle check that stays active during reset.
`define FSKRRC_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fskrrc_pkg.sv @@
// ----------------------------------------------------------------------------
// fskrrc_pkg
// Types, constants and coefficient tables of the 4FSK RRC modulator.
// ----------------------------------------------------------------------------
package fskrrc_pkg;

    localparam int TAP_COUNT     = 150;
    localparam int INTERP_FACTOR = 10;
    localparam int COEF_WIDTH    = 16;
    localparam int COEF_FRAC     = COEF_WIDTH - 2;
    localparam int ROM_TAPS      = 150;
    localparam int ROM_HALF      = 75;
    localparam int HIST_DEPTH    = (TAP_COUNT + INTERP_FACTOR - 1) / INTERP_FACTOR;
    localparam int PHASE_W       = $clog2(INTERP_FACTOR);
    localparam int SYM_W         = 3;
    localparam int PROD_W        = COEF_WIDTH + SYM_W;
    localparam int GROUP_SIZE    = 5;
    localparam int N_GROUPS      = (HIST_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PART_W        = PROD_W + $clog2(GROUP_SIZE);
    localparam int ACC_W         = PART_W + $clog2(N_GROUPS + 1);
    localparam int OUT_SCALE     = 7168;
    localparam int SCALE_W       = $clog2(OUT_SCALE) + 1;
    localparam int SCL_W         = ACC_W + SCALE_W;
    localparam int Y_W           = SCL_W - COEF_FRAC + 1;
    localparam int ROUND_BIAS    = (1 << COEF_FRAC) - 1;
    localparam int SAMPLE_W      = 16;
    localparam int SAMPLE_MAX    = 32767;
    localparam int SAMPLE_MIN    = -32768;

    typedef logic signed [SYM_W-1:0]      sym_t;
    typedef sym_t [HIST_DEPTH-1:0]        hist_t;
    typedef logic signed [COEF_WIDTH-1:0] coef_t;
    typedef logic signed [PART_W-1:0]     part_t;
    typedef part_t [N_GROUPS-1:0]         parts_t;
    typedef logic [PHASE_W-1:0]           phase_t;
    typedef logic signed [SAMPLE_W-1:0]   sample_t;

    typedef enum logic [1:0] {
        DIBIT_P1 = 2'd0,
        DIBIT_P3 = 2'd1,
        DIBIT_M1 = 2'd2,
        DIBIT_M3 = 2'd3
    } dibit_t;

    // Control that travels with the phase being computed.
    typedef struct packed {
        logic   valid;
        logic   last;
        phase_t phase;
    } tap_ctl_t;

    // Control that travels with a partial result down the pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } flow_t;

    // First half of the symmetric RRC taps in Q2.14.
    localparam int RRC_HALF [ROM_HALF] = '{
        48, 52, 44, 27, 4, -21, -42, -54, -54, -41,
        -17, 13, 42, 64, 73, 66, 44, 9, -30, -67,
        -93, -100, -88, -56, -11, 39, 81, 107, 108, 82,
        33, -30, -94, -143, -166, -152, -101, -18, 80, 176,
        247, 275, 250, 171, 50, -91, -220, -305, -319, -246,
        -88, 132, 374, 582, 695, 660, 438, 23, -556, -1229,
        -1891, -2409, -2641, -2453, -1738, -441, 1435, 3816, 6563, 9480,
        12334, 14881, 16891, 18179, 18622
    };

    function automatic sym_t map_symbol(input logic [1:0] dibit, input logic flush);
        sym_t s;
        unique case (dibit_t'(dibit))
            DIBIT_P1: s = 3'sd1;
            DIBIT_P3: s = 3'sd3;
            DIBIT_M1: s = -3'sd1;
            DIBIT_M3: s = -3'sd3;
            default:  s = '0;
        endcase
        if (flush)
        begin
            s = '0;
        end
        return s;
    endfunction

    function automatic int rom_q14(input int k);
        int c;
        c = 0;
        if (k >= 0 && k < ROM_HALF)
        begin
            c = RRC_HALF[k];
        end
        else if (k >= ROM_HALF && k < ROM_TAPS - 1)
        begin
            c = RRC_HALF[ROM_TAPS - 2 - k];
        end
        return c;
    endfunction

    // Q2.14 tap brought to COEF_FRAC fraction bits; narrower formats round half up.
    function automatic coef_t coef_at(input int k);
        int    c;
        int    sh;
        int    biased;
        coef_t r;
        c = rom_q14(k);
        if (COEF_FRAC >= 14)
        begin
            sh = COEF_FRAC - 14;
            r  = coef_t'(c <<< sh);
        end
        else
        begin
            sh     = 14 - COEF_FRAC;
            biased = c + 65536 + (1 <<< (sh - 1));
            r      = coef_t'((biased >>> sh) - (65536 >>> sh));
        end
        return r;
    endfunction

    // Polyphase tap for output phase p and history slot m.
    function automatic coef_t coef_tap(input phase_t p, input int m);
        int    k;
        coef_t r;
        k = int'(p) + INTERP_FACTOR * m;
        r = '0;
        if (k < TAP_COUNT)
        begin
            r = coef_at(k);
        end
        return r;
    endfunction

endpackage

@@ rtl/core/fskrrc_in_if.sv @@
// ----------------------------------------------------------------------------
// fskrrc_in_if
// Symbol request channel: one dibit or a flush symbol.
// ----------------------------------------------------------------------------
interface fskrrc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] dibit;
    logic       flush_symbol;

    modport source (output valid, output dibit, output flush_symbol, input ready);
    modport sink   (input valid, input dibit, input flush_symbol, output ready);
endinterface

@@ rtl/core/fskrrc_out_if.sv @@
// ----------------------------------------------------------------------------
// fskrrc_out_if
// Baseband sample channel.
// ----------------------------------------------------------------------------
interface fskrrc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               last_of_symbol;

    modport source (output valid, output sample, output last_of_symbol, input ready);
    modport sink   (input valid, input sample, input last_of_symbol, output ready);
endinterface

@@ rtl/core/fskrrc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// fskrrc_cfg_if
// Configuration write channel for the output inversion register.
// ----------------------------------------------------------------------------
interface fskrrc_cfg_if;
    logic valid;
    logic ready;
    logic invert_output;

    modport source (output valid, output invert_output, input ready);
    modport sink   (input valid, input invert_output, output ready);
endinterface

@@ rtl/core/fskrrc_seq.sv @@
// ----------------------------------------------------------------------------
// fskrrc_seq
// Symbol history shift register and output phase sequencer.
// ----------------------------------------------------------------------------
module fskrrc_seq import fskrrc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  logic [1:0] dibit,
    input  logic       flush_symbol,
    output logic       in_ready,
    output hist_t      hist,
    output tap_ctl_t   tap_ctl
);

    logic   busy_reg,  busy_next;
    phase_t phase_reg, phase_next;
    hist_t  hist_reg,  hist_next;
    logic   last_phase;
    logic   accept;

    assign last_phase = (phase_reg == phase_t'(INTERP_FACTOR - 1));
    // A new symbol may enter in the cycle the last phase of the previous one is issued.
    assign in_ready   = en && (!busy_reg || last_phase);
    assign accept     = in_valid && in_ready;

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        hist_next  = hist_reg;
        if (accept)
        begin
            busy_next  = 1'b1;
            phase_next = '0;
            hist_next  = {hist_reg[HIST_DEPTH-2:0], map_symbol(dibit, flush_symbol)};
        end
        else if (en && busy_reg)
        begin
            if (last_phase)
            begin
                busy_next  = 1'b0;
                phase_next = '0;
            end
            else
            begin
                phase_next = phase_reg + phase_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= '0;
            hist_reg  <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            hist_reg  <= hist_next;
        end
    end

    assign hist          = hist_reg;
    assign tap_ctl.valid = busy_reg;
    assign tap_ctl.last  = last_phase;
    assign tap_ctl.phase = phase_reg;

endmodule

@@ rtl/core/fskrrc_dot.sv @@
// ----------------------------------------------------------------------------
// fskrrc_dot
// Polyphase products of the history with one phase of taps, summed in groups.
// ----------------------------------------------------------------------------
module fskrrc_dot import fskrrc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  tap_ctl_t tap_ctl,
    input  hist_t    hist,
    output flow_t    flow,
    output parts_t   parts
);

    logic signed [PROD_W-1:0] prod [HIST_DEPTH];
    parts_t parts_reg, parts_next;
    flow_t  flow_reg;

    always_comb
    begin
        for (int m = 0; m < HIST_DEPTH; m++)
        begin
            prod[m] = PROD_W'(coef_tap(tap_ctl.phase, m)) * PROD_W'(hist[m]);
        end
    end

    always_comb
    begin
        for (int g = 0; g < N_GROUPS; g++)
        begin
            parts_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                if (g * GROUP_SIZE + j < HIST_DEPTH)
                begin
                    parts_next[g] = parts_next[g] + PART_W'(prod[g * GROUP_SIZE + j]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_reg <= '0;
        end
        else if (en)
        begin
            flow_reg.valid <= tap_ctl.valid;
            flow_reg.last  <= tap_ctl.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            parts_reg <= parts_next;
        end
    end

    assign flow  = flow_reg;
    assign parts = parts_reg;

endmodule

@@ rtl/core/fskrrc_post.sv @@
// ----------------------------------------------------------------------------
// fskrrc_post
// Final sum and gain, then truncation, optional negation and saturation.
// ----------------------------------------------------------------------------
module fskrrc_post import fskrrc_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    invert,
    input  flow_t   flow,
    input  parts_t  parts,
    output logic    out_valid,
    output sample_t sample,
    output logic    last_of_symbol
);

    logic signed [ACC_W-1:0] acc;
    logic signed [SCL_W-1:0] scaled_reg, scaled_next;
    logic signed [SCL_W-1:0] biased;
    logic signed [Y_W-1:0]   y;
    flow_t   flow_reg;
    flow_t   out_flow_reg;
    sample_t sample_reg, sample_next;

    always_comb
    begin
        acc = '0;
        for (int g = 0; g < N_GROUPS; g++)
        begin
            acc = acc + ACC_W'(parts[g]);
        end
        scaled_next = SCL_W'(acc) * SCL_W'(OUT_SCALE);
    end

    // Arithmetic shift rounds down, so negative values get a bias to round toward zero.
    always_comb
    begin
        biased = scaled_reg;
        if (scaled_reg < 0)
        begin
            biased = scaled_reg + SCL_W'(ROUND_BIAS);
        end
        y = Y_W'(biased >>> COEF_FRAC);
        if (invert)
        begin
            y = -y;
        end
        if (y > Y_W'(SAMPLE_MAX))
        begin
            sample_next = sample_t'(SAMPLE_MAX);
        end
        else if (y < Y_W'(SAMPLE_MIN))
        begin
            sample_next = sample_t'(SAMPLE_MIN);
        end
        else
        begin
            sample_next = sample_t'(y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_reg     <= '0;
            out_flow_reg <= '0;
        end
        else if (en)
        begin
            flow_reg     <= flow;
            out_flow_reg <= flow_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            scaled_reg <= scaled_next;
            sample_reg <= sample_next;
        end
    end

    assign out_valid      = out_flow_reg.valid;
    assign sample         = sample_reg;
    assign last_of_symbol = out_flow_reg.last;

endmodule

@@ rtl/core/fourfsk_rrc_interpolating_modulator.sv @@
// Path: sequencer history and phase registers, partial-sum register, scaled-sum register,
// output sample register. Throughput: one sample per cycle; the phase sequencer issues
// the ten polyphase phases of a symbol one per cycle and takes the next symbol with
// the last phase. Output backpressure stalls the whole pipeline.
// Reset: asynchronous, active low; clears the symbol history to zero symbols, the sequencer,
// all valid flags and the inversion register.
// ----------------------------------------------------------------------------
// fourfsk_rrc_interpolating_modulator
// 4FSK symbol mapper with a polyphase root-raised-cosine interpolator.
// ----------------------------------------------------------------------------
module fourfsk_rrc_interpolating_modulator import fskrrc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    fskrrc_in_if.sink    symbol,
    fskrrc_out_if.source baseband,
    fskrrc_cfg_if.sink   cfg
);

    logic     en;
    logic     invert_reg;
    logic     out_valid;
    sample_t  sample;
    logic     last_of_symbol;
    hist_t    hist;
    tap_ctl_t tap_ctl;
    flow_t    flow;
    parts_t   parts;

    assign en        = !out_valid || baseband.ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            invert_reg <= cfg.invert_output;
        end
    end

    fskrrc_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (symbol.valid),
        .dibit        (symbol.dibit),
        .flush_symbol (symbol.flush_symbol),
        .in_ready     (symbol.ready),
        .hist         (hist),
        .tap_ctl      (tap_ctl)
    );

    fskrrc_dot u_dot (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .tap_ctl (tap_ctl),
        .hist    (hist),
        .flow    (flow),
        .parts   (parts)
    );

    fskrrc_post u_post (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .invert         (invert_reg),
        .flow           (flow),
        .parts          (parts),
        .out_valid      (out_valid),
        .sample         (sample),
        .last_of_symbol (last_of_symbol)
    );

    assign baseband.valid          = out_valid;
    assign baseband.sample         = sample;
    assign baseband.last_of_symbol = last_of_symbol;

endmodule

@@ rtl/core/fskrrc_checker.sv @@
// ----------------------------------------------------------------------------
// fskrrc_checker
// Port-level checks of the 4FSK modulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "fourfsk_rrc_interpolating_modulator_assert.svh"

module fskrrc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] sample,
    input logic        last_of_symbol
);

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // Each symbol occupies the sequencer for all its phases, so requests never land back to back.
    `FSKRRC_ASSERT_NEXT(a_no_b2b_symbols, clk, rst_n, in_acc, !in_acc, "symbols accepted in consecutive cycles")

    // A stalled output stalls the symbol input as well.
    `FSKRRC_ASSERT_NOW(a_input_stalls, clk, rst_n, in_ready, !out_valid || out_ready, "input ready while output stalled")

    // A sample that is not taken stays unchanged.
    `FSKRRC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(sample) && $stable(last_of_symbol), "stalled sample changed")

endmodule

bind fourfsk_rrc_interpolating_modulator fskrrc_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (symbol.valid),
    .in_ready       (symbol.ready),
    .out_valid      (baseband.valid),
    .out_ready      (baseband.ready),
    .sample         (baseband.sample),
    .last_of_symbol (baseband.last_of_symbol)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4FSK RRC interpolating modulator. Symbol
// requests go in, and a polyphase filter model in the bench computes the ten
// baseband samples that each symbol must produce. Every sample that leaves
// the block is checked against the oldest pending prediction. Sender gaps,
// receiver stalls, a long output hold-off and both settings of the output
// inversion register are exercised.
// ----------------------------------------------------------------------------
module tb_top;
    import fskrrc_pkg::*;

    localparam int N_PHASES     = 10;
    localparam int N_HIST       = 15;
    localparam int N_TAPS       = 150;
    localparam int ROM_LAST     = 149;
    localparam int Q_FRAC       = 14;
    localparam int GAIN         = 7168;
    localparam int S16_MAX      = 32767;
    localparam int S16_MIN      = -32768;
    localparam int SETTLE       = 12;
    localparam int MAX_GAP      = 64;
    localparam int LIMIT_CYCLES = 500000;

    // First half of the symmetric RRC impulse response, Q2.14.
    localparam int RRC_Q14_HALF [75] = '{
        48, 52, 44, 27, 4, -21, -42, -54, -54, -41,
        -17, 13, 42, 64, 73, 66, 44, 9, -30, -67,
        -93, -100, -88, -56, -11, 39, 81, 107, 108, 82,
        33, -30, -94, -143, -166, -152, -101, -18, 80, 176,
        247, 275, 250, 171, 50, -91, -220, -305, -319, -246,
        -88, 132, 374, 582, 695, 660, 438, 23, -556, -1229,
        -1891, -2409, -2641, -2453, -1738, -441, 1435, 3816, 6563, 9480,
        12334, 14881, 16891, 18179, 18622
    };

    typedef struct {
        sample_t sample;
        logic    last;
    } bb_sample_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    fskrrc_in_if  sym_if ();
    fskrrc_out_if bb_if ();
    fskrrc_cfg_if cfg_if ();

    fourfsk_rrc_interpolating_modulator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .symbol   (sym_if),
        .baseband (bb_if),
        .cfg      (cfg_if)
    );

    bb_sample_t pending_samples[$];
    int         symbol_line[N_HIST] = '{default: 0};
    logic       invert_sel     = 1'b0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         stall_hold     = 0;
    int         mismatch_count = 0;
    int         cycle_count    = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Tap k of the full 150-tap response; the last tap is zero.
    function automatic int rrc_tap(input int k);
        int c;
        c = 0;
        if (k >= 0 && k < 75)
        begin
            c = RRC_Q14_HALF[k];
        end
        else if (k >= 75 && k < ROM_LAST)
        begin
            c = RRC_Q14_HALF[148 - k];
        end
        return c;
    endfunction

    // Shifts one symbol into the delay line and queues the ten samples it causes.
    task automatic filter_symbol(input logic [1:0] dibit, input logic flush);
        int         level;
        int         k;
        longint     acc;
        longint     y;
        bb_sample_t s;
        level = 0;
        if (!flush)
        begin
            case (dibit_t'(dibit))
                DIBIT_P1: level = 1;
                DIBIT_P3: level = 3;
                DIBIT_M1: level = -1;
                DIBIT_M3: level = -3;
                default:  level = 0;
            endcase
        end
        for (int m = N_HIST - 1; m > 0; m--)
        begin
            symbol_line[m] = symbol_line[m - 1];
        end
        symbol_line[0] = level;
        for (int p = 0; p < N_PHASES; p++)
        begin
            acc = 0;
            for (int m = 0; m < N_HIST; m++)
            begin
                k = p + N_PHASES * m;
                if (k < N_TAPS)
                begin
                    acc += longint'(rrc_tap(k)) * longint'(symbol_line[m]);
                end
            end
            // Signed division truncates toward zero.
            y = (acc * GAIN) / (longint'(1) << Q_FRAC);
            if (invert_sel)
            begin
                y = -y;
            end
            if (y > S16_MAX)
            begin
                y = S16_MAX;
            end
            if (y < S16_MIN)
            begin
                y = S16_MIN;
            end
            s.sample = sample_t'(y);
            s.last   = (p == N_PHASES - 1);
            pending_samples.push_back(s);
        end
    endtask

    // Offers one symbol request, with a random gap first, and waits until it is taken.
    task automatic send_symbol(input logic [1:0] dibit, input logic flush);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        @(negedge clk);
        while (gap > 0)
        begin
            sym_if.valid <= 1'b0;
            gap--;
            @(negedge clk);
        end
        sym_if.valid        <= 1'b1;
        sym_if.dibit        <= dibit;
        sym_if.flush_symbol <= flush;
        do
        begin
            @(posedge clk);
        end
        while (!sym_if.ready);
        filter_symbol(dibit, flush);
    endtask

    task automatic send_random_symbol();
        send_symbol(2'($urandom_range(3)), $urandom_range(7) == 0);
    endtask

    // Drops the request line and waits until every predicted sample has come out.
    task automatic wait_drained();
        @(negedge clk);
        sym_if.valid <= 1'b0;
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_invert(input logic value);
        wait_drained();
        @(negedge clk);
        cfg_if.valid         <= 1'b1;
        cfg_if.invert_output <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_if.ready);
        invert_sel = value;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Fills the delay line so that every tap of the strongest phase adds with
    // the same sign; this drives the output toward full scale.
    task automatic send_peak_pattern();
        int best_phase;
        int best_sum;
        int sum;
        int m;
        best_phase = 0;
        best_sum   = 0;
        for (int p = 0; p < N_PHASES; p++)
        begin
            sum = 0;
            for (int j = 0; j < N_HIST; j++)
            begin
                sum += (rrc_tap(p + N_PHASES * j) < 0) ? -rrc_tap(p + N_PHASES * j)
                                                         : rrc_tap(p + N_PHASES * j);
            end
            if (sum > best_sum)
            begin
                best_sum   = sum;
                best_phase = p;
            end
        end
        for (int i = 0; i < N_HIST; i++)
        begin
            m = N_HIST - 1 - i;
            if (rrc_tap(best_phase + N_PHASES * m) < 0)
            begin
                send_symbol(DIBIT_M3, 1'b0);
            end
            else
            begin
                send_symbol(DIBIT_P3, 1'b0);
            end
        end
    endtask

    task automatic test_symbol_map();
        write_invert(1'b0);
        send_symbol(DIBIT_P1, 1'b0);
        send_symbol(DIBIT_P3, 1'b0);
        send_symbol(DIBIT_M1, 1'b0);
        send_symbol(DIBIT_M3, 1'b0);
        // A flush must ignore whatever dibit rides along with it.
        send_symbol(DIBIT_M3, 1'b1);
        send_symbol(DIBIT_P1, 1'b1);
        send_peak_pattern();
    endtask

    task automatic test_invert();
        write_invert(1'b1);
        send_peak_pattern();
        send_symbol(DIBIT_M1, 1'b0);
        send_symbol(DIBIT_M3, 1'b1);
    endtask

    task automatic test_random_traffic();
        int send_pct [4] = '{0, 77, 0, 37};
        int recv_pct [4] = '{0, 0, 77, 37};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_invert(ph[0]);
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            repeat (96) send_random_symbol();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_output_holdoff();
        write_invert(1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_symbol();
        stall_hold = 300;
        repeat (40) send_random_symbol();
        recv_stall_pct = 20;
        send_idle_pct  = 20;
        repeat (8) send_random_symbol();
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            bb_if.ready <= 1'b0;
        end
        else if (stall_hold > 0)
        begin
            bb_if.ready <= 1'b0;
            stall_hold  <= stall_hold - 1;
        end
        else
        begin
            bb_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        bb_sample_t exp_s;
        if (rst_n && bb_if.valid && bb_if.ready)
        begin
            if (pending_samples.size() == 0)
            begin
                $error("sample %0d arrived with no prediction pending", bb_if.sample);
                mismatch_count++;
            end
            else
            begin
                exp_s = pending_samples.pop_front();
                if (bb_if.sample !== exp_s.sample)
                begin
                    $error("sample: expected %0d, got %0d", exp_s.sample, bb_if.sample);
                    mismatch_count++;
                end
                if (bb_if.last_of_symbol !== exp_s.last)
                begin
                    $error("last_of_symbol: expected %0b, got %0b",
                           exp_s.last, bb_if.last_of_symbol);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        sym_if.valid         = 1'b0;
        sym_if.dibit         = 2'b00;
        sym_if.flush_symbol  = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.invert_output = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_symbol_map();
        test_invert();
        test_random_traffic();
        test_output_holdoff();
        wait_drained();

        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
